/* rtl/waiting_queue_with_cancel_top_defines.svh */
// Assertion macros used by the checker file of the waiting queue.
`ifndef WAITING_QUEUE_WITH_CANCEL_TOP_DEFINES_SVH
`define WAITING_QUEUE_WITH_CANCEL_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define WQC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("waiting queue check failed");

// Next-cycle implication, disabled while reset is high.
`define WQC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("waiting queue check failed");

`endif

/* rtl/wqc_pkg.sv */
`timescale 1ns / 1ps

package wqc_pkg;

   localparam int KIND_W   = 3;
   localparam int KEY_W    = 32;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_ARRIVE   = 3'd0,
      KIND_WITHDRAW = 3'd1,
      KIND_SERVE    = 3'd2,
      KIND_LIST     = 3'd3,
      KIND_FLUSH    = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SEARCH,
      S_COMPACT,
      S_SERVE,
      S_LIST
   } state_type;

endpackage

/* rtl/wqc_req_if.sv */
`timescale 1ns / 1ps

interface wqc_req_if;
   import wqc_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [KEY_W-1:0]  key;

   modport source (output valid, output kind, output key, input ready);
   modport sink (input valid, input kind, input key, output ready);
endinterface

/* rtl/wqc_rsp_if.sv */
`timescale 1ns / 1ps

interface wqc_rsp_if;
   import wqc_pkg::*;

   logic                valid;
   logic                ready;
   logic [KEY_W-1:0]    out_key;
   logic [POS_W-1:0]    position;
   logic [STATUS_W-1:0] status;
   logic                last;

   modport source (output valid, output out_key, output position, output status,
                   output last, input ready);
   modport sink (input valid, input out_key, input position, input status,
                 input last, output ready);
endinterface

/* rtl/wqc_ram.sv */
`timescale 1ns / 1ps

module wqc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/waiting_queue_with_cancel_top.sv */
`timescale 1ns / 1ps

// Bounded FIFO waiting queue of keys with removal by key.
// The req channel carries one command transaction (kind, key); the rsp channel
// returns result transactions (out_key, position, status, last). Every command
// but an unused kind gives at least one result, and last marks its final one.
// Commands are taken one at a time: req ready is high only while the block is
// idle, but a finished result may still sit in the output register then.
// Entries live in a ring buffer held in one RAM with a registered read; every
// search, copy and listing step goes through its single read port.
// Arrive and flush load their result from the execute state; serve reads the
// head entry and loads it as the result. In withdraw the search reads one entry a cycle
// and the gap is closed by a read-one, write-one copy of the later entries.
// List reads the entries in turn and waits for each result to be loaded before the next read.
// When the receiver stalls, the output register holds its result and the
// block waits before loading the next one; nothing is dropped.
// Reset (synchronous) empties the queue; RAM contents are not cleared.
module waiting_queue_with_cancel_top #(
   parameter int DEPTH     = 16,
   parameter int KEY_WIDTH = 32
) (
   input logic       clock,
   input logic       reset,
   wqc_req_if.sink   req_if,
   wqc_rsp_if.source rsp_if
);
   import wqc_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      return (p == LAST_ADDR) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
      return (p == '0) ? LAST_ADDR : p - 1'b1;
   endfunction

   state_type             state_ff, state_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [KEY_WIDTH-1:0]  key_ff, key_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [AW-1:0]         tail_ff, tail_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         src_ptr_ff, src_ptr_in;
   logic [CW-1:0]         src_left_ff, src_left_in;
   logic [AW-1:0]         cap_ptr_ff, cap_ptr_in;
   logic                  rd_vld_ff;
   logic [CW-1:0]         pos_ff, pos_in;

   logic                  rsp_valid_ff;
   logic [KEY_W-1:0]      rsp_key_ff;
   logic [POS_W-1:0]      rsp_pos_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic                  rsp_last_ff;

   logic                  req_accept;
   logic                  out_free;
   logic                  full;
   logic                  empty;
   logic                  drain_done;
   logic                  search_hit;
   logic                  issue;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [KEY_WIDTH-1:0]  wr_data;
   logic [KEY_WIDTH-1:0]  rd_data;

   logic                  load;
   logic [KEY_W-1:0]      ld_key;
   logic [POS_W-1:0]      ld_pos;
   status_type            ld_status;
   logic                  ld_last;

   logic [KEY_W+KEY_WIDTH-1:0] key_wide;
   logic [KEY_W+KEY_WIDTH-1:0] rd_wide;
   logic [CW+POS_W-1:0]        pos_wide;

   assign req_accept = req_if.valid && req_if.ready;
   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign full       = (count_ff == FULL_COUNT);
   assign empty      = (count_ff == '0);
   assign drain_done = (src_left_ff == '0) && !rd_vld_ff;
   assign search_hit = rd_vld_ff && (rd_data == key_ff);

   assign key_wide = (KEY_W + KEY_WIDTH)'(req_if.key);
   assign rd_wide  = (KEY_W + KEY_WIDTH)'(rd_data);
   assign pos_wide = (CW + POS_W)'(pos_ff) + (CW + POS_W)'(1);

   wqc_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (src_ptr_ff),
      .rd_data (rd_data)
   );

   // Search and copy read one entry a cycle; serve and list only read when the
   // output register will be free to take the data in the cycle after the read.
   always_comb begin
      unique case (state_ff)
         S_SEARCH, S_COMPACT: issue = (src_left_ff != '0);
         S_SERVE, S_LIST:     issue = (src_left_ff != '0) && !rd_vld_ff && out_free;
         default:             issue = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            unique case (kind_ff)
               KIND_ARRIVE, KIND_FLUSH: begin
                  if (out_free) state_in = S_IDLE;
               end
               KIND_WITHDRAW: state_in = S_SEARCH;
               KIND_SERVE: begin
                  if (!empty) state_in = S_SERVE;
                  else if (out_free) state_in = S_IDLE;
               end
               KIND_LIST: begin
                  if (!empty) state_in = S_LIST;
                  else if (out_free) state_in = S_IDLE;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_SEARCH: begin
            if (search_hit) state_in = S_COMPACT;
            else if (drain_done && out_free) state_in = S_IDLE;
         end
         S_COMPACT: begin
            if (drain_done && out_free) state_in = S_IDLE;
         end
         S_SERVE: begin
            if (rd_vld_ff) state_in = S_IDLE;
         end
         S_LIST: begin
            if (rd_vld_ff && (src_left_ff == '0)) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      kind_in     = kind_ff;
      key_in      = key_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      src_ptr_in  = issue ? ptr_inc(src_ptr_ff) : src_ptr_ff;
      src_left_in = issue ? src_left_ff - 1'b1 : src_left_ff;
      cap_ptr_in  = cap_ptr_ff;
      pos_in      = pos_ff;
      wr_en       = 1'b0;
      wr_addr     = tail_ff;
      wr_data     = key_ff;
      load        = 1'b0;
      ld_key      = '0;
      ld_pos      = '0;
      ld_status   = ST_OK;
      ld_last     = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               kind_in = req_if.kind;
               key_in  = key_wide[KEY_WIDTH-1:0];
            end
         end
         S_EXEC: begin
            unique case (kind_ff)
               KIND_ARRIVE: begin
                  if (out_free) begin
                     load = 1'b1;
                     if (full) begin
                        ld_status = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        tail_in  = ptr_inc(tail_ff);
                        count_in = count_ff + 1'b1;
                     end
                  end
               end
               KIND_WITHDRAW: begin
                  src_ptr_in  = head_ff;
                  src_left_in = count_ff;
               end
               KIND_SERVE: begin
                  if (!empty) begin
                     src_ptr_in  = head_ff;
                     src_left_in = CW'(1);
                  end else if (out_free) begin
                     load      = 1'b1;
                     ld_status = ST_EMPTY;
                  end
               end
               KIND_LIST: begin
                  if (!empty) begin
                     src_ptr_in  = head_ff;
                     src_left_in = count_ff;
                     pos_in      = '0;
                  end else if (out_free) begin
                     load      = 1'b1;
                     ld_status = ST_EMPTY;
                  end
               end
               KIND_FLUSH: begin
                  if (out_free) begin
                     load     = 1'b1;
                     head_in  = '0;
                     tail_in  = '0;
                     count_in = '0;
                  end
               end
               default: ;
            endcase
         end
         S_SEARCH: begin
            // On a hit, cap_ptr keeps the matching slot: it becomes the first
            // slot that the copy overwrites.
            if (!search_hit && issue) begin
               cap_ptr_in = src_ptr_ff;
            end
            if (!search_hit && drain_done && out_free) begin
               load      = 1'b1;
               ld_status = ST_NOT_FOUND;
            end
         end
         S_COMPACT: begin
            if (rd_vld_ff) begin
               wr_en      = 1'b1;
               wr_addr    = cap_ptr_ff;
               wr_data    = rd_data;
               cap_ptr_in = ptr_inc(cap_ptr_ff);
            end
            if (drain_done && out_free) begin
               load     = 1'b1;
               tail_in  = ptr_dec(tail_ff);
               count_in = count_ff - 1'b1;
            end
         end
         S_SERVE: begin
            if (rd_vld_ff) begin
               load     = 1'b1;
               ld_key   = rd_wide[KEY_W-1:0];
               head_in  = ptr_inc(head_ff);
               count_in = count_ff - 1'b1;
            end
         end
         S_LIST: begin
            if (rd_vld_ff) begin
               load    = 1'b1;
               ld_key  = rd_wide[KEY_W-1:0];
               ld_pos  = pos_wide[POS_W-1:0];
               ld_last = (src_left_ff == '0);
               pos_in  = pos_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         src_left_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         src_left_ff  <= src_left_in;
         rd_vld_ff    <= issue;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      key_ff     <= key_in;
      src_ptr_ff <= src_ptr_in;
      cap_ptr_ff <= cap_ptr_in;
      pos_ff     <= pos_in;
      if (load) begin
         rsp_key_ff    <= ld_key;
         rsp_pos_ff    <= ld_pos;
         rsp_status_ff <= ld_status;
         rsp_last_ff   <= ld_last;
      end
   end

   assign req_if.ready    = (state_ff == S_IDLE);
   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.out_key  = rsp_key_ff;
   assign rsp_if.position = rsp_pos_ff;
   assign rsp_if.status   = rsp_status_ff;
   assign rsp_if.last     = rsp_last_ff;

endmodule

/* rtl/wqc_checker.sv */
`timescale 1ns / 1ps
`include "waiting_queue_with_cancel_top_defines.svh"

module wqc_checker (
   input logic       clock,
   input logic       reset,
   wqc_req_if.sink   req_if,
   wqc_rsp_if.source rsp_if
);
   import wqc_pkg::*;

   // A result that is not taken stays offered.
   `WQC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_if.valid && !rsp_if.ready, rsp_if.valid)

   // Commands are worked one at a time, so an accepted transaction closes the door.
   `WQC_ASSERT_NEXT(a_req_one_at_a_time, clock, reset, req_if.valid && req_if.ready, !req_if.ready)

   // Every error result is the only result of its command.
   `WQC_ASSERT_NOW(a_error_is_last, clock, reset, rsp_if.valid && (rsp_if.status != ST_OK), rsp_if.last)

   // Only listed entries carry a position, and those always report success.
   `WQC_ASSERT_NOW(a_position_ok, clock, reset, rsp_if.valid && (rsp_if.position != '0), rsp_if.status == ST_OK)

endmodule

bind waiting_queue_with_cancel_top wqc_checker u_wqc_checker (
   .clock  (clock),
   .reset  (reset),
   .req_if (req_if),
   .rsp_if (rsp_if)
);

/* sim/waiting_queue_with_cancel_top_tb.sv */
`timescale 1ns / 1ps

module waiting_queue_with_cancel_top_tb;
   import wqc_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 80;
   localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
   localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;

   typedef struct {
      logic [KEY_W-1:0]    out_key;
      logic [POS_W-1:0]    position;
      status_type          status;
      logic                last;
   } reply_type;

   logic clock;
   logic reset;

   wqc_req_if req_ch();
   wqc_rsp_if rsp_ch();

   waiting_queue_with_cancel_top #(
      .DEPTH(QUEUE_DEPTH),
      .KEY_WIDTH(KEY_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch)
   );

   // Our own copy of the waiting line, head at index 0.
   logic [KEY_W-1:0] model_line[$];
   reply_type expected_replies[$];

   bit req_gaps_on;
   bit rsp_stalls_on;
   int stall_left;
   int cycle_count;
   int error_count;
   int commands_sent;
   int replies_checked;
   int full_count;
   int not_found_count;
   int empty_count;
   int withdraw_hits;

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d replies still expected", $time,
                  expected_replies.size());
         $display("waiting_queue_with_cancel_top_tb: FAIL");
         $finish;
      end
   end

   // Receiver back-pressure: random stalls while rsp_stalls_on is set.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_stalls_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         replies_checked++;
         if (expected_replies.size() == 0) begin
            error_count++;
            $display("%0t: unexpected reply: expected none, got key %h pos %0d status %0d last %0b",
                     $time, rsp_ch.out_key, rsp_ch.position, rsp_ch.status, rsp_ch.last);
         end else begin
            want = expected_replies.pop_front();
            if (rsp_ch.out_key !== want.out_key || rsp_ch.position !== want.position ||
                rsp_ch.status !== want.status || rsp_ch.last !== want.last) begin
               error_count++;
               $display("%0t: reply mismatch: expected key %h pos %0d status %0d last %0b",
                        $time, want.out_key, want.position, want.status, want.last);
               $display("%0t:                 actual   key %h pos %0d status %0d last %0b",
                        $time, rsp_ch.out_key, rsp_ch.position, rsp_ch.status, rsp_ch.last);
            end
         end
      end
   end

   // Apply one accepted command to the waiting line and queue up its replies.
   function automatic void predict_replies(input logic [KIND_W-1:0] kind,
                                           input logic [KEY_W-1:0] key);
      reply_type r;
      int hit;
      hit = -1;
      r.out_key = '0;
      r.position = '0;
      r.status = ST_OK;
      r.last = 1'b1;
      case (kind)
         KIND_ARRIVE: begin
            if (model_line.size() >= QUEUE_DEPTH) begin
               r.status = ST_FULL;
               full_count++;
            end else begin
               model_line.push_back(key);
            end
            expected_replies.push_back(r);
         end
         KIND_WITHDRAW: begin
            foreach (model_line[i])
               if (hit < 0 && model_line[i] == key) hit = i;
            if (hit < 0) begin
               r.status = ST_NOT_FOUND;
               not_found_count++;
            end else begin
               model_line.delete(hit);
               withdraw_hits++;
            end
            expected_replies.push_back(r);
         end
         KIND_SERVE: begin
            if (model_line.size() == 0) begin
               r.status = ST_EMPTY;
               empty_count++;
            end else begin
               r.out_key = model_line.pop_front();
            end
            expected_replies.push_back(r);
         end
         KIND_LIST: begin
            if (model_line.size() == 0) begin
               r.status = ST_EMPTY;
               empty_count++;
               expected_replies.push_back(r);
            end else begin
               foreach (model_line[i]) begin
                  r.out_key = model_line[i];
                  r.position = POS_W'(i + 1);
                  r.last = (i == model_line.size() - 1);
                  expected_replies.push_back(r);
               end
            end
         end
         KIND_FLUSH: begin
            model_line.delete();
            expected_replies.push_back(r);
         end
         default: ;
      endcase
   endfunction

   // Leaves valid high after acceptance; a drain lowers it, and the next call may.
   task automatic send_command(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key);
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= kind;
      req_ch.key <= key;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      commands_sent++;
      predict_replies(kind, key);
   endtask

   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_replies.size() != 0);
   endtask

   task automatic test_empty_queue();
      send_command(KIND_LIST, '0);
      send_command(KIND_SERVE, '1);
      send_command(KIND_WITHDRAW, '0);
      for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
         send_command(KIND_W'(k), '1);
   endtask

   task automatic test_fill_to_capacity();
      logic [KEY_W-1:0] fill_key;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         case (i)
            0: fill_key = '0;
            1: fill_key = '1;
            2, 6: fill_key = 32'hA5A5_A5A5;
            3: fill_key = 32'h5A5A_5A5A;
            4: fill_key = 32'h8000_0000;
            default: fill_key = 32'h0000_0100 + i;
         endcase
         send_command(KIND_ARRIVE, fill_key);
      end
      send_command(KIND_ARRIVE, 32'hDEAD_BEEF);
      send_command(KIND_LIST, '0);
   endtask

   task automatic test_withdraw_cases();
      // The duplicate key must leave its later copy in place.
      send_command(KIND_WITHDRAW, 32'hA5A5_A5A5);
      send_command(KIND_WITHDRAW, 32'h1234_5678);
      send_command(KIND_WITHDRAW, 32'h0000_010F);
      send_command(KIND_LIST, '0);
   endtask

   task automatic test_serve_and_flush();
      send_command(KIND_SERVE, '0);
      send_command(KIND_FLUSH, '1);
      send_command(KIND_SERVE, '0);
   endtask

   task automatic test_random_traffic(input int item_total, input int arrive_weight,
                                      input bit with_idling);
      int counted;
      int sel;
      logic [KIND_W-1:0] kind_bits;
      logic [KEY_W-1:0] key_bits;
      counted = 0;
      req_gaps_on = with_idling;
      rsp_stalls_on = with_idling;
      while (counted < item_total) begin
         sel = $urandom_range(0, arrive_weight + 57);
         // A small key pool makes duplicates and repeated withdraws likely.
         if ($urandom_range(0, 3) == 0) key_bits = KEY_W'($urandom_range(0, 7));
         else key_bits = KEY_W'($urandom());
         if (sel < arrive_weight) begin
            kind_bits = KIND_ARRIVE;
         end else if (sel < arrive_weight + 25) begin
            kind_bits = KIND_WITHDRAW;
            if (model_line.size() != 0 && $urandom_range(0, 1) == 1)
               key_bits = model_line[$urandom_range(0, model_line.size() - 1)];
         end else if (sel < arrive_weight + 40) begin
            kind_bits = KIND_SERVE;
         end else if (sel < arrive_weight + 50) begin
            kind_bits = KIND_LIST;
         end else if (sel < arrive_weight + 53) begin
            kind_bits = KIND_FLUSH;
         end else begin
            kind_bits = KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
         end
         if (kind_bits <= KIND_FLUSH) counted++;
         send_command(kind_bits, key_bits);
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.kind <= KIND_ARRIVE;
      req_ch.key <= '0;
      stall_left = 0;
      cycle_count = 0;
      error_count = 0;
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_fill_to_capacity();
      test_withdraw_cases();
      test_serve_and_flush();
      wait_for_drain();
      test_random_traffic(75, 70, 1'b1);
      wait_for_drain();
      test_random_traffic(65, 35, 1'b1);
      test_random_traffic(45, 45, 1'b0);
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d commands and %0d checked replies.", commands_sent,
               replies_checked);
      $display("Full %0d, not found %0d, empty %0d, withdraw hits %0d.", full_count,
               not_found_count, empty_count, withdraw_hits);
      if (error_count == 0) begin
         $display("waiting_queue_with_cancel_top_tb: PASS");
      end else begin
         $display("waiting_queue_with_cancel_top_tb: FAIL");
      end
      $finish;
   end

endmodule
